// ----- sv/dfp_pkg.sv -----
// Shared types, codes and constants for the delimited decimal field parser.
// Used by dfp_core, dfp_queue and delimited_decimal_field_parser.
// No dependencies.
package dfp_pkg;

    // Result queue depth; a power of two, at least 2
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes and reset values
    localparam logic CFG_DELIMITER  = 1'b0;
    localparam logic CFG_MAX_FIELDS = 1'b1;
    localparam logic [7:0] DELIMITER_RESET  = 8'd58;
    localparam logic [7:0] MAX_FIELDS_RESET = 8'd3;

    // Result codes
    localparam logic KIND_VALUE   = 1'b0;
    localparam logic KIND_OUTCOME = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // Magnitude saturates at 2^31
    localparam logic [31:0] MAG_CAP = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        PH_START,
        PH_LEADWS,
        PH_SIGNED,
        PH_DIGITS,
        PH_FAILED
    } phase_t;

    typedef struct packed {
        logic               kind;
        logic [7:0]         field_index;
        logic signed [31:0] value;
        logic               status;
        logic [8:0]         field_count;
        logic               last;
    } result_t;

    typedef struct packed {
        logic fire;
        logic fire_end;
        logic cleared;
    } core_stat_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ----- sv/dfp_queue.sv -----
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on dfp_pkg (result_t).
module dfp_queue #(
    parameter int DEPTH = dfp_pkg::QUEUE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [1:0]                   push_cnt,
    input  dfp_pkg::result_t             push0,
    input  dfp_pkg::result_t             push1,
    output logic                         room,
    output logic [$clog2(DEPTH):0]       level,
    output logic                         head_valid,
    output dfp_pkg::result_t             head,
    input  logic                         pop
);
    localparam int AW = $clog2(DEPTH);

    dfp_pkg::result_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic [AW-1:0] wr_ptr_plus1;
    logic          do_pop;

    assign do_pop       = pop && (count_reg != '0);
    assign wr_ptr_plus1 = AW'(wr_ptr_reg + 1'b1);

    always_comb
    begin
        wr_ptr_next = AW'(wr_ptr_reg + push_cnt);
        rd_ptr_next = do_pop ? AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = (AW+1)'(count_reg + {{(AW-1){1'b0}}, push_cnt} - {{AW{1'b0}}, do_pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem[wr_ptr_reg] <= push0;
        if (push_cnt == 2'd2)
            mem[wr_ptr_plus1] <= push1;
    end

    // Keep two slots free so an end item that closes a number always fits
    assign room       = count_reg <= (AW+1)'(DEPTH - 2);
    assign level      = count_reg;
    assign head_valid = count_reg != '0;
    assign head       = mem[rd_ptr_reg];

endmodule

// ----- sv/dfp_core.sv -----
// Parser core: input register, configuration registers, parse state and
// the combinational parse step that produces up to two results.
// Depends on dfp_pkg.
module dfp_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           character,
    input  logic                 is_end,
    input  logic                 room,
    output logic [1:0]           push_cnt,
    output dfp_pkg::result_t     res0,
    output dfp_pkg::result_t     res1,
    output dfp_pkg::core_stat_t  stat
);
    logic [7:0] delim_reg, maxf_reg;

    logic       v_reg, v_next;
    logic [7:0] char_reg;
    logic       end_reg;

    dfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      cnt_reg, cnt_next;
    logic [31:0]     mag_reg, mag_next;
    logic            neg_reg, neg_next;

    logic        accept, fire;
    logic        c_space, c_digit, c_sign, c_delim, below_max;
    logic [31:0] mag_base, mag_add, sval;
    logic [35:0] mag_prod;
    dfp_pkg::phase_t bn_phase;
    logic            bn_neg;
    logic [31:0]     bn_mag;

    assign in_stall = v_reg && !room;
    assign accept   = in_valid && !in_stall;
    assign fire     = v_reg && room;
    assign v_next   = accept ? 1'b1 : (fire ? 1'b0 : v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= dfp_pkg::DELIMITER_RESET;
            maxf_reg  <= dfp_pkg::MAX_FIELDS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dfp_pkg::CFG_DELIMITER:  delim_reg <= cfg_data;
                dfp_pkg::CFG_MAX_FIELDS: maxf_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= character;
            end_reg  <= is_end;
        end
    end

    // Character classes
    assign c_space   = dfp_pkg::is_space(char_reg);
    assign c_digit   = dfp_pkg::is_digit(char_reg);
    assign c_sign    = (char_reg == dfp_pkg::CH_PLUS) || (char_reg == dfp_pkg::CH_MINUS);
    assign c_delim   = char_reg == delim_reg;
    assign below_max = cnt_reg < maxf_reg;

    // magnitude * 10 + digit, saturated at 2^31; a fresh number starts from zero
    assign mag_base = (phase_reg == dfp_pkg::PH_DIGITS) ? mag_reg : 32'd0;
    assign mag_prod = ({4'd0, mag_base} << 3) + ({4'd0, mag_base} << 1)
                    + {32'd0, char_reg[3:0]};
    assign mag_add  = (mag_prod > {4'd0, dfp_pkg::MAG_CAP}) ? dfp_pkg::MAG_CAP
                                                           : mag_prod[31:0];

    assign sval = neg_reg ? (32'd0 - mag_reg)
                          : ((mag_reg > dfp_pkg::INT_MAX) ? dfp_pkg::INT_MAX : mag_reg);

    // Start of a number after whitespace or at field start
    always_comb
    begin
        if (c_sign)
        begin
            bn_phase = dfp_pkg::PH_SIGNED;
            bn_neg   = char_reg == dfp_pkg::CH_MINUS;
            bn_mag   = 32'd0;
        end
        else if (c_digit)
        begin
            bn_phase = dfp_pkg::PH_DIGITS;
            bn_neg   = 1'b0;
            bn_mag   = mag_add;
        end
        else
        begin
            bn_phase = dfp_pkg::PH_FAILED;
            bn_neg   = 1'b0;
            bn_mag   = 32'd0;
        end
    end

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        if (fire)
        begin
            if (end_reg)
            begin
                phase_next = dfp_pkg::PH_START;
                cnt_next   = 8'd0;
                mag_next   = 32'd0;
                neg_next   = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    dfp_pkg::PH_START:
                    begin
                        // Once the slots are used up, ignore everything until the end
                        if (below_max)
                        begin
                            if (c_delim)
                                cnt_next = 8'(cnt_reg + 1'b1);
                            else if (c_space)
                            begin
                                phase_next = dfp_pkg::PH_LEADWS;
                                mag_next   = 32'd0;
                                neg_next   = 1'b0;
                            end
                            else
                            begin
                                phase_next = bn_phase;
                                mag_next   = bn_mag;
                                neg_next   = bn_neg;
                            end
                        end
                    end
                    dfp_pkg::PH_LEADWS:
                    begin
                        if (!c_space)
                        begin
                            phase_next = bn_phase;
                            mag_next   = bn_mag;
                            neg_next   = bn_neg;
                        end
                    end
                    dfp_pkg::PH_SIGNED:
                    begin
                        if (c_digit)
                        begin
                            phase_next = dfp_pkg::PH_DIGITS;
                            mag_next   = mag_add;
                        end
                        else
                            phase_next = dfp_pkg::PH_FAILED;
                    end
                    dfp_pkg::PH_DIGITS:
                    begin
                        if (c_digit)
                            mag_next = mag_add;
                        else if (c_delim)
                        begin
                            if (below_max)
                                cnt_next = 8'(cnt_reg + 1'b1);
                            phase_next = dfp_pkg::PH_START;
                            mag_next   = 32'd0;
                            neg_next   = 1'b0;
                        end
                        else
                            phase_next = dfp_pkg::PH_FAILED;
                    end
                    default:
                        phase_next = dfp_pkg::PH_FAILED;
                endcase
            end
        end
    end

    // Results
    always_comb
    begin
        res0     = '0;
        res1     = '0;
        push_cnt = 2'd0;
        if (fire)
        begin
            if (end_reg)
            begin
                if (phase_reg == dfp_pkg::PH_DIGITS)
                begin
                    res0.kind        = dfp_pkg::KIND_VALUE;
                    res0.field_index = cnt_reg;
                    res0.value       = sval;
                    res0.last        = 1'b0;
                    res1.kind        = dfp_pkg::KIND_OUTCOME;
                    res1.status      = dfp_pkg::STATUS_OK;
                    res1.field_count = 9'({1'b0, cnt_reg} + 9'd1);
                    res1.last        = 1'b1;
                    push_cnt         = 2'd2;
                end
                else
                begin
                    res0.kind = dfp_pkg::KIND_OUTCOME;
                    res0.last = 1'b1;
                    if ((phase_reg == dfp_pkg::PH_LEADWS) || (phase_reg == dfp_pkg::PH_SIGNED)
                        || (phase_reg == dfp_pkg::PH_FAILED))
                        res0.status = dfp_pkg::STATUS_ERROR;
                    else
                    begin
                        res0.status      = dfp_pkg::STATUS_OK;
                        res0.field_count = 9'({1'b0, cnt_reg} + 9'd1);
                    end
                    push_cnt = 2'd1;
                end
            end
            else if ((phase_reg == dfp_pkg::PH_DIGITS) && !c_digit && c_delim)
            begin
                res0.kind        = dfp_pkg::KIND_VALUE;
                res0.field_index = cnt_reg;
                res0.value       = sval;
                res0.last        = 1'b1;
                push_cnt         = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= 1'b0;
            phase_reg <= dfp_pkg::PH_START;
            cnt_reg   <= 8'd0;
            mag_reg   <= 32'd0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            v_reg     <= v_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
        end
    end

    assign stat.fire     = fire;
    assign stat.fire_end = fire && end_reg;
    assign stat.cleared  = (phase_reg == dfp_pkg::PH_START) && (cnt_reg == 8'd0)
                         && (mag_reg == 32'd0) && !neg_reg;

endmodule

// ----- sv/delimited_decimal_field_parser.sv -----
// Delimited decimal field parser, top level: parser core and result queue.
// Depends on dfp_pkg, dfp_core and dfp_queue.
//
// Takes one character per transfer and sustains one character per clock
// while the queue has room. A character is held in an input register,
// where the parse step (a multiply by ten and add on the 32-bit magnitude)
// runs, and its results go from there into a result queue of QUEUE_DEPTH
// entries, whose head is the output. An end item that closes a number
// gives two results (the value write and the outcome), so a waiting
// character is held and input stalled while the queue has fewer than two
// free entries, which costs nothing while the output drains every cycle.
module delimited_decimal_field_parser #(
    parameter int QUEUE_DEPTH = dfp_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         character,
    input  logic               is_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic [7:0]         field_index,
    output logic signed [31:0] value,
    output logic               status,
    output logic [8:0]         field_count,
    output logic               last
);
    logic [1:0]                   push_cnt;
    dfp_pkg::result_t             res0, res1, head;
    dfp_pkg::core_stat_t          stat;
    logic                         room;
    logic [$clog2(QUEUE_DEPTH):0] level;

    dfp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .character (character),
        .is_end    (is_end),
        .room      (room),
        .push_cnt  (push_cnt),
        .res0      (res0),
        .res1      (res1),
        .stat      (stat)
    );

    dfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push0      (res0),
        .push1      (res1),
        .room       (room),
        .level      (level),
        .head_valid (out_valid),
        .head       (head),
        .pop        (!out_stall)
    );

    assign kind        = head.kind;
    assign field_index = head.field_index;
    assign value       = head.value;
    assign status      = head.status;
    assign field_count = head.field_count;
    assign last        = head.last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH))
        else $error("result queue over-filled");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        stat.fire_end |=> stat.cleared)
        else $error("parse state not cleared after end item");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt == 2'd2) |-> (!res0.last && res1.last
                                && (res1.kind == dfp_pkg::KIND_OUTCOME)))
        else $error("value write and outcome pushed out of order");

    a_outcome_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == dfp_pkg::KIND_OUTCOME)) |-> last)
        else $error("outcome not marked last");

endmodule

// ----- tb/sv/delimited_decimal_field_parser_test.sv -----
// Self-checking testbench for delimited_decimal_field_parser: directed strings,
// field-limit and back-pressure runs, then random records under random idling.
// Depends on dfp_pkg and the parser RTL.
module delimited_decimal_field_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 1200;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = dfp_pkg::CFG_DELIMITER;
    logic [7:0]         cfg_data = 8'd0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         character = 8'd0;
    logic               is_end = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               kind;
    logic [7:0]         field_index;
    logic signed [31:0] value;
    logic               status;
    logic [8:0]         field_count;
    logic               last;

    // Parser state as this bench tracks it
    logic [7:0]       delim = dfp_pkg::DELIMITER_RESET;
    logic [7:0]       slot_limit = dfp_pkg::MAX_FIELDS_RESET;
    dfp_pkg::phase_t  scan_phase = dfp_pkg::PH_START;
    logic [7:0]       slot = 8'd0;
    logic [31:0]      magnitude_acc = 32'd0;
    logic             minus = 1'b0;

    dfp_pkg::result_t predicted_results[$];
    int          errors = 0;
    int          chars_sent = 0;
    int          cycle_count = 0;
    logic        in_gaps = 1'b1;
    logic        out_gaps = 1'b1;
    logic        hold_off = 1'b0;
    int          stall_left = 0;
    event        hold_go;

    delimited_decimal_field_parser u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .character   (character),
        .is_end      (is_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .field_index (field_index),
        .value       (value),
        .status      (status),
        .field_count (field_count),
        .last        (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------
    function automatic logic blank_char(input logic [7:0] c);
        return (c == dfp_pkg::CH_SPACE) || (c >= dfp_pkg::CH_TAB && c <= dfp_pkg::CH_CR);
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= dfp_pkg::CH_ZERO) && (c <= dfp_pkg::CH_NINE);
    endfunction

    // Multiply by ten and add, clamped at 2^31
    function automatic logic [31:0] accumulate(input logic [31:0] m, input logic [7:0] c);
        logic [63:0] t;
        t = {32'd0, m} * 64'd10 + {56'd0, c - dfp_pkg::CH_ZERO};
        return (t > {32'd0, dfp_pkg::MAG_CAP}) ? dfp_pkg::MAG_CAP : t[31:0];
    endfunction

    function automatic logic [31:0] field_value();
        if (minus)
            return 32'd0 - magnitude_acc;
        return (magnitude_acc > dfp_pkg::INT_MAX) ? dfp_pkg::INT_MAX : magnitude_acc;
    endfunction

    task automatic expect_result(input logic k, input logic [7:0] idx, input logic [31:0] val,
                                 input logic st, input logic [8:0] cnt, input logic lst);
        dfp_pkg::result_t r;
        r.kind        = k;
        r.field_index = idx;
        r.value       = val;
        r.status      = st;
        r.field_count = cnt;
        r.last        = lst;
        predicted_results.push_back(r);
    endtask

    task automatic open_number(input logic [7:0] c);
        if (c == dfp_pkg::CH_PLUS || c == dfp_pkg::CH_MINUS)
        begin
            minus = (c == dfp_pkg::CH_MINUS);
            scan_phase = dfp_pkg::PH_SIGNED;
        end
        else if (digit_char(c))
        begin
            magnitude_acc = accumulate(32'd0, c);
            scan_phase = dfp_pkg::PH_DIGITS;
        end
        else
            scan_phase = dfp_pkg::PH_FAILED;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic e);
        if (e)
        begin
            if (scan_phase == dfp_pkg::PH_DIGITS)
                expect_result(dfp_pkg::KIND_VALUE, slot, field_value(), dfp_pkg::STATUS_OK,
                              9'd0, 1'b0);
            if (scan_phase == dfp_pkg::PH_LEADWS || scan_phase == dfp_pkg::PH_SIGNED
                || scan_phase == dfp_pkg::PH_FAILED)
                expect_result(dfp_pkg::KIND_OUTCOME, 8'd0, 32'd0, dfp_pkg::STATUS_ERROR,
                              9'd0, 1'b1);
            else
                expect_result(dfp_pkg::KIND_OUTCOME, 8'd0, 32'd0, dfp_pkg::STATUS_OK,
                              {1'b0, slot} + 9'd1, 1'b1);
            scan_phase = dfp_pkg::PH_START;
            slot = 8'd0;
            magnitude_acc = 32'd0;
            minus = 1'b0;
            return;
        end
        case (scan_phase)
            dfp_pkg::PH_START:
                // Past the last slot: drop everything up to the end item
                if (slot < slot_limit)
                begin
                    if (c == delim)
                        slot = slot + 8'd1;
                    else
                    begin
                        magnitude_acc = 32'd0;
                        minus = 1'b0;
                        if (blank_char(c))
                            scan_phase = dfp_pkg::PH_LEADWS;
                        else
                            open_number(c);
                    end
                end
            dfp_pkg::PH_LEADWS:
                if (!blank_char(c))
                    open_number(c);
            dfp_pkg::PH_SIGNED:
                if (digit_char(c))
                begin
                    magnitude_acc = accumulate(32'd0, c);
                    scan_phase = dfp_pkg::PH_DIGITS;
                end
                else
                    scan_phase = dfp_pkg::PH_FAILED;
            dfp_pkg::PH_DIGITS:
                if (digit_char(c))
                    magnitude_acc = accumulate(magnitude_acc, c);
                else if (c == delim)
                begin
                    expect_result(dfp_pkg::KIND_VALUE, slot, field_value(), dfp_pkg::STATUS_OK,
                                  9'd0, 1'b1);
                    if (slot < slot_limit)
                        slot = slot + 8'd1;
                    magnitude_acc = 32'd0;
                    minus = 1'b0;
                    scan_phase = dfp_pkg::PH_START;
                end
                else
                    scan_phase = dfp_pkg::PH_FAILED;
            default:
                scan_phase = dfp_pkg::PH_FAILED;
        endcase
    endtask

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        dfp_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("result transfer with nothing expected: kind %0b value 'h%0h",
                       kind, value);
                errors++;
            end
            else
            begin
                want = predicted_results.pop_front();
                compare_field("kind", want.kind, kind);
                compare_field("field_index", want.field_index, field_index);
                compare_field("value", want.value, value);
                compare_field("status", want.status, status);
                compare_field("field_count", want.field_count, field_count);
                compare_field("last", want.last, last);
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random stall after each transfer, plus the long hold-off
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            stall_left = out_gaps ? $urandom_range(0, 6) : 0;
        else if (stall_left > 0)
            stall_left--;
        out_stall <= hold_off || (stall_left > 0);
    end

    initial
    begin
        forever
        begin
            @(hold_go);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Sender and configuration
    // ---------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic e);
        int gap;
        gap = in_gaps ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        character <= c;
        is_end    <= e;
        do
            @(posedge clk);
        while (in_stall);
        chars_sent++;
        parse_char(c, e);
    endtask

    task automatic send_end();
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
        send_end();
    endtask

    // Hold the input until every result is out, then let the core settle
    task automatic drain();
        in_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == dfp_pkg::CFG_DELIMITER)
            delim = data;
        else
            slot_limit = data;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_basic_fields();
        // Default delimiter and three slots; the fourth field is dropped
        send_string("12:-34: +5");
        send_string("1:2:3:4");
    endtask

    task automatic test_extreme_values();
        send_string("-2147483648:99999999999");
    endtask

    task automatic test_syntax_errors();
        send_string("");
        send_string(" ");
        send_string("+");
        send_string("1x");
        send_string(":");
        // NUL is an ordinary character, not a terminator
        send_char(8'd0, 1'b0);
        send_end();
    endtask

    task automatic test_delimiter_as_digit();
        drain();
        write_reg(dfp_pkg::CFG_DELIMITER, "5");
        send_string("5152");
        drain();
        write_reg(dfp_pkg::CFG_DELIMITER, dfp_pkg::DELIMITER_RESET);
    endtask

    task automatic test_no_slots();
        drain();
        write_reg(dfp_pkg::CFG_MAX_FIELDS, 8'd0);
        send_string("12");
        drain();
        write_reg(dfp_pkg::CFG_MAX_FIELDS, dfp_pkg::MAX_FIELDS_RESET);
    endtask

    task automatic test_config_mid_string();
        send_char("7", 1'b0);
        drain();
        write_reg(dfp_pkg::CFG_DELIMITER, ",");
        send_string(",8");
        drain();
        write_reg(dfp_pkg::CFG_DELIMITER, dfp_pkg::DELIMITER_RESET);
    endtask

    task automatic test_all_slots();
        drain();
        write_reg(dfp_pkg::CFG_MAX_FIELDS, 8'd255);
        // Value into the top slot, then the largest field count
        repeat (254) send_char(dfp_pkg::DELIMITER_RESET, 1'b0);
        send_string("7");
        repeat (255) send_char(dfp_pkg::DELIMITER_RESET, 1'b0);
        send_end();
    endtask

    task automatic test_back_pressure();
        drain();
        in_gaps = 1'b0;
        -> hold_go;
        // Keep offering while the receiver holds off so the queue fills
        for (int i = 1; i <= 40; i++)
        begin
            send_char(dfp_pkg::CH_ZERO + 8'(i % 10), 1'b0);
            send_char(dfp_pkg::DELIMITER_RESET, 1'b0);
        end
        send_string("9");
        drain();
        in_gaps = 1'b1;
    endtask

    task automatic send_random_field();
        int shape;
        int n;
        shape = $urandom_range(0, 15);
        if (shape == 0)
            return;
        repeat ($urandom_range(0, 2))
            send_char(($urandom_range(0, 5) == 5) ? dfp_pkg::CH_SPACE
                                                  : dfp_pkg::CH_TAB + 8'($urandom_range(0, 4)),
                      1'b0);
        if (shape == 1)
        begin
            send_char(8'($urandom_range(0, 255)), 1'b0);
            return;
        end
        if ($urandom_range(0, 2) == 0)
            send_char($urandom_range(0, 1) ? dfp_pkg::CH_MINUS : dfp_pkg::CH_PLUS, 1'b0);
        if (shape == 2)
            return;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
        repeat (n)
            send_char(dfp_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        if (shape == 3)
            send_char(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_random_record();
        int n;
        if ($urandom_range(0, 9) == 0)
        begin
            // Noise
            n = $urandom_range(0, 8);
            repeat (n)
                send_char(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            n = $urandom_range(1, 5);
            for (int f = 0; f < n; f++)
            begin
                if (f > 0)
                    send_char(delim, 1'b0);
                send_random_field();
            end
        end
        send_end();
    endtask

    task automatic pick_random_setting();
        logic [7:0] d;
        logic [7:0] m;
        case ($urandom_range(0, 9))
            0: d = 8'd1;
            1: d = 8'd255;
            2: d = ":";
            3: d = ",";
            4: d = dfp_pkg::CH_SPACE;
            5: d = "5";
            6: d = dfp_pkg::CH_MINUS;
            default: d = 8'($urandom_range(1, 255));
        endcase
        case ($urandom_range(0, 7))
            0: m = 8'd0;
            1: m = 8'd255;
            default: m = 8'($urandom_range(1, 6));
        endcase
        drain();
        write_reg(dfp_pkg::CFG_DELIMITER, d);
        write_reg(dfp_pkg::CFG_MAX_FIELDS, m);
        in_gaps = ($urandom_range(0, 3) != 0);
        out_gaps <= ($urandom_range(0, 3) != 0);
    endtask

    task automatic test_random_strings();
        int stop_at;
        stop_at = chars_sent + RANDOM_ITEMS;
        pick_random_setting();
        while (chars_sent < stop_at)
        begin
            if ($urandom_range(0, 24) == 0)
                pick_random_setting();
            send_random_record();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_fields();
        test_extreme_values();
        test_syntax_errors();
        test_delimiter_as_digit();
        test_no_slots();
        test_config_mid_string();
        test_all_slots();
        test_back_pressure();
        test_random_strings();
        drain();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
sv/dfp_pkg.sv
sv/dfp_queue.sv
sv/dfp_core.sv
sv/delimited_decimal_field_parser.sv
tb/sv/delimited_decimal_field_parser_test.sv
